// ===== rtl/fsps_pkg.sv =====
// Package for the fair-share priority scheduler: widths, codes and helpers.
// No dependencies.
`timescale 1ns / 1ps
package fsps_pkg;
    localparam int MAX_PROCS = 16;
    localparam int IDX_W = $clog2(MAX_PROCS);
    localparam int CNT_W = $clog2(MAX_PROCS + 1);
    localparam int PRIO_W = 19;
    localparam int STAMP_W = 32;
    localparam logic [15:0] CHARGE = 16'd20;
    localparam logic [PRIO_W-1:0] BASE_PRIO = 19'd60;

    typedef enum logic [2:0] {
        K_INSERT = 3'd0, K_CHARGE = 3'd1, K_QEND = 3'd2, K_DISPATCH = 3'd3, K_MOVE = 3'd4
    } t_kind;

    localparam logic [1:0] L_FREE = 2'd0;
    localparam logic [1:0] L_READY = 2'd1;
    localparam logic [1:0] L_RUN = 2'd2;
    localparam logic [1:0] L_SUSP = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [7:0] id;
        logic [3:0] grp;
        logic [15:0] cpu;
        logic [15:0] gcpu;
        logic [PRIO_W-1:0] prio;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] chosen_id;
        logic [PRIO_W-1:0] chosen_prio;
        logic [3:0] groups;
    } t_result;
endpackage

// ===== rtl/fsps_ram.sv =====
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
`timescale 1ns / 1ps
module fsps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/fsps_alu.sv =====
// Shared per-entry update unit: charge, halve and priority recompute.
// Depends on fsps_pkg.
`timescale 1ns / 1ps
module fsps_alu (
    input  fsps_pkg::t_entry      i_entry,
    input  logic [1:0]            i_list,
    input  logic [2:0]            i_kind,
    input  logic [3:0]            i_grp,
    input  logic [3:0]            i_groups,
    output fsps_pkg::t_entry      o_entry
);
    import fsps_pkg::*;
    logic [16:0] w_sum;
    logic [15:0] w_cpu;
    logic [15:0] w_gcpu;
    logic [19:0] w_mul;
    logic [PRIO_W:0] w_prio;

    // quantum end cost is one 16x4 multiply and two adds per entry
    always_comb begin
        o_entry = i_entry;
        w_sum = {1'b0, i_entry.gcpu} + {1'b0, CHARGE};
        w_cpu = i_entry.cpu >> 1;
        w_gcpu = i_entry.gcpu >> 1;
        w_mul = w_gcpu * i_groups;
        w_prio = {1'b0, BASE_PRIO} + {5'd0, w_cpu[15:1]} + {2'b0, w_mul[19:2]};
        case (i_kind)
            K_CHARGE: begin
                if (i_list == L_READY && i_entry.grp == i_grp) begin
                    o_entry.gcpu = w_sum[16] ? 16'hFFFF : w_sum[15:0];
                end
            end
            K_QEND: begin
                if (i_list == L_READY || i_list == L_SUSP) begin
                    o_entry.cpu = w_cpu;
                    o_entry.gcpu = w_gcpu;
                end
                if (i_list == L_READY) begin
                    o_entry.prio = w_prio[PRIO_W-1:0];
                end
            end
            default: ;
        endcase
    end
endmodule

// ===== rtl/fair_share_priority_scheduler.sv =====
// Top level of the fair-share priority scheduler: sequencer, list tags, entry RAM.
// Depends on fsps_pkg, fsps_ram, fsps_alu.
`timescale 1ns / 1ps
// channel   | dir | handshake                  | payload
// s_axis    | in  | s_axis_tvalid/tready       | tdata {target,gcpu,cpu,grp,id}, tuser kind
// m_axis    | out | m_axis_tvalid/tready       | tdata {groups,prio,id,status}
// cfg       | in  | i_cfg_valid/o_cfg_ready    | max_group
// An event scans the table one entry per cycle through one RAM read port, but an insert
// takes its free slot from the tag bits without a scan. Quantum end first runs a group
// pass over groups 1..max_group; every event ends with a write-back step and the
// output register.
// Reset is synchronous; the table is valid at once.
// The result waits in an output register; the next event is taken only after it drains.
module fair_share_priority_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // id[7:0] grp[11:8] cpu[27:12] gcpu[43:28] target[45:44]
    input  logic [2:0]  s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // status[1:0] id[9:2] prio[28:10] groups[32:29]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data
);
    import fsps_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_GROUPS, S_SCAN, S_WRITE, S_OUT} t_state;

    t_state r_state;
    logic [1:0] r_list [MAX_PROCS];
    logic [2:0] r_kind;
    logic [7:0] r_pid;
    logic [3:0] r_gid;
    logic [15:0] r_cpu0, r_gcpu0;
    logic [1:0] r_target;
    logic [3:0] r_max_group, r_groups, r_gscan, r_ngroups;
    logic [STAMP_W-1:0] r_stamp_ctr;
    logic [CNT_W-1:0] r_cnt;
    logic r_pipe_v;
    logic [IDX_W-1:0] r_pipe_idx;
    logic r_found;
    logic [IDX_W-1:0] r_best;
    t_entry r_best_e;
    t_result r_res;

    logic w_we;
    logic [IDX_W-1:0] w_waddr, w_raddr;
    t_entry w_wdata, w_rdata, w_alu;
    logic [1:0] w_plist;
    logic w_better;
    logic w_free_found;
    logic [IDX_W-1:0] w_free_idx;
    logic [1:0] w_status;

    fsps_ram #(.WIDTH($bits(t_entry)), .DEPTH(MAX_PROCS)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    fsps_alu u_alu (
        .i_entry(w_rdata), .i_list(w_plist), .i_kind(r_kind),
        .i_grp(r_gid), .i_groups(r_groups), .o_entry(w_alu)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata = {7'd0, r_res.groups, r_res.chosen_prio, r_res.chosen_id, r_res.status};
    assign w_raddr = r_cnt[IDX_W-1:0];
    assign w_plist = r_list[r_pipe_idx];

    // group presence uses group bits held in a side copy
    logic [3:0] r_grp [MAX_PROCS];
    logic w_hit;
    always_comb begin
        w_hit = 1'b0;
        for (int i = 0; i < MAX_PROCS; i++) begin
            if (r_list[i] != L_FREE && r_grp[i] == r_gscan) begin
                w_hit = 1'b1;
            end
        end
    end

    // lowest free slot from the tag bits
    always_comb begin
        w_free_found = 1'b0;
        w_free_idx = '0;
        for (int i = MAX_PROCS - 1; i >= 0; i--) begin
            if (r_list[i] == L_FREE) begin
                w_free_found = 1'b1;
                w_free_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        w_status = ST_OK;
        case (r_kind)
            K_INSERT: if (!r_found) w_status = ST_FULL;
            K_DISPATCH: if (!r_found) w_status = ST_NONE;
            K_MOVE: if (!r_found) w_status = ST_NOTFOUND;
            default: w_status = ST_OK;
        endcase
    end

    always_comb begin
        w_better = 1'b0;
        case (r_kind)
            K_DISPATCH: w_better = (w_plist == L_READY) && (!r_found
                || w_rdata.prio < r_best_e.prio
                || (w_rdata.prio == r_best_e.prio && w_rdata.stamp < r_best_e.stamp));
            K_MOVE: w_better = (w_plist != L_FREE) && (w_rdata.id == r_pid)
                && (!r_found || w_rdata.stamp < r_best_e.stamp);
            default: w_better = 1'b0;
        endcase
    end

    always_comb begin
        w_we = 1'b0;
        w_waddr = r_pipe_idx;
        w_wdata = w_alu;
        if (r_state == S_SCAN && r_pipe_v && (r_kind == K_CHARGE || r_kind == K_QEND)) begin
            w_we = 1'b1;
        end else if (r_state == S_WRITE && r_found) begin
            w_we = 1'b1;
            w_waddr = r_best;
            w_wdata = r_best_e;
            w_wdata.stamp = r_stamp_ctr;
            if (r_kind == K_INSERT) begin
                w_wdata.id = r_pid;
                w_wdata.grp = r_gid;
                w_wdata.cpu = r_cpu0;
                w_wdata.gcpu = r_gcpu0;
                w_wdata.prio = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_max_group <= 4'd15;
            r_groups <= '0;
            r_stamp_ctr <= '0;
            r_pipe_v <= 1'b0;
            r_found <= 1'b0;
            for (int i = 0; i < MAX_PROCS; i++) r_list[i] <= L_FREE;
        end else begin
            if (i_cfg_valid) r_max_group <= i_cfg_data;
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_kind <= s_axis_tuser;
                        r_pid <= s_axis_tdata[7:0];
                        r_gid <= s_axis_tdata[11:8];
                        r_cpu0 <= s_axis_tdata[27:12];
                        r_gcpu0 <= s_axis_tdata[43:28];
                        r_target <= s_axis_tdata[45:44];
                        r_found <= 1'b0;
                        r_pipe_v <= 1'b0;
                        r_cnt <= '0;
                        r_gscan <= 4'd1;
                        r_ngroups <= '0;
                        case (t_kind'(s_axis_tuser))
                            K_INSERT, K_CHARGE, K_DISPATCH, K_MOVE: r_state <= S_SCAN;
                            K_QEND: r_state <= S_GROUPS;
                            default: r_state <= S_WRITE;
                        endcase
                    end
                end
                S_GROUPS: begin
                    if (r_gscan <= r_max_group && r_gscan != 4'd0) begin
                        if (w_hit) r_ngroups <= r_ngroups + 4'd1;
                        r_gscan <= r_gscan + 4'd1;
                    end else begin
                        r_groups <= r_ngroups;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_kind == K_INSERT) begin
                        r_best <= w_free_idx;
                        r_found <= w_free_found;
                        r_state <= S_WRITE;
                    end else begin
                        r_pipe_v <= (r_cnt < CNT_W'(MAX_PROCS));
                        r_pipe_idx <= r_cnt[IDX_W-1:0];
                        if (r_cnt < CNT_W'(MAX_PROCS)) r_cnt <= r_cnt + 1'b1;
                        if (r_pipe_v && w_better) begin
                            r_found <= 1'b1;
                            r_best <= r_pipe_idx;
                            r_best_e <= w_rdata;
                        end
                        if (r_pipe_v && r_pipe_idx == IDX_W'(MAX_PROCS - 1)) r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_res.groups <= r_groups;
                    r_res.status <= w_status;
                    r_res.chosen_id <= (r_kind == K_DISPATCH && r_found) ? r_best_e.id : '0;
                    r_res.chosen_prio <= (r_kind == K_DISPATCH && r_found) ? r_best_e.prio : '0;
                    case (t_kind'(r_kind))
                        K_INSERT: begin
                            if (r_found) begin
                                r_list[r_best] <= L_READY;
                                r_grp[r_best] <= r_gid;
                                r_stamp_ctr <= r_stamp_ctr + 1'b1;
                            end
                        end
                        K_DISPATCH: begin
                            if (r_found) begin
                                r_list[r_best] <= L_RUN;
                                r_stamp_ctr <= r_stamp_ctr + 1'b1;
                            end
                        end
                        K_MOVE: begin
                            if (r_found) begin
                                r_list[r_best] <= r_target;
                                if (r_target != L_FREE) r_stamp_ctr <= r_stamp_ctr + 1'b1;
                            end
                        end
                        default: ;
                    endcase
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (m_axis_tready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // stamp counter advances only in the write-back state of a transaction that restamps an entry
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_WRITE) |=> $stable(r_stamp_ctr))
        else $error("stamp counter moved outside write-back");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !m_axis_tready) |=> (r_state == S_OUT && $stable(r_res)))
        else $error("result changed while stalled");
endmodule

// ===== bench/tb_fair_share_priority_scheduler.sv =====
// Self-checking bench for fair_share_priority_scheduler: directed and random events
// through the stream ports, results checked against an in-bench scheduler table.
// Depends on fsps_pkg and the scheduler RTL.
`timescale 1ns / 1ps
module tb_fair_share_priority_scheduler;
    import fsps_pkg::*;

    typedef struct {
        logic [2:0]  kind;
        logic [7:0]  pid;
        logic [3:0]  gid;
        logic [15:0] cpu;
        logic [15:0] gcpu;
        logic [1:0]  target;
    } t_event;

    class sched_scoreboard;
        logic [1:0]  lst [MAX_PROCS];
        logic [7:0]  pid [MAX_PROCS];
        logic [3:0]  grp [MAX_PROCS];
        logic [15:0] cpu [MAX_PROCS];
        logic [15:0] gcpu [MAX_PROCS];
        logic [18:0] prio [MAX_PROCS];
        logic [31:0] stamp [MAX_PROCS];
        logic [31:0] next_stamp;
        logic [3:0]  groups;
        logic [3:0]  max_group;
        t_result     pending [$];
        int          errors;

        function new();
            for (int i = 0; i < MAX_PROCS; i++) begin
                lst[i] = L_FREE;
                prio[i] = '0;
            end
            next_stamp = '0;
            groups = '0;
            max_group = 4'd15;
            errors = 0;
        endfunction

        function int count_ready();
            int n;
            n = 0;
            for (int i = 0; i < MAX_PROCS; i++) if (lst[i] == L_READY) n++;
            return n;
        endfunction

        function int count_used();
            int n;
            n = 0;
            for (int i = 0; i < MAX_PROCS; i++) if (lst[i] != L_FREE) n++;
            return n;
        endfunction

        function void note_event(t_event e);
            t_result r;
            int best;
            logic [31:0] p;
            logic [16:0] s;
            r = '0;
            best = -1;
            case (e.kind)
                K_INSERT: begin
                    for (int i = MAX_PROCS - 1; i >= 0; i--) if (lst[i] == L_FREE) best = i;
                    if (best < 0) r.status = ST_FULL;
                    else begin
                        lst[best] = L_READY; pid[best] = e.pid; grp[best] = e.gid;
                        cpu[best] = e.cpu; gcpu[best] = e.gcpu; prio[best] = '0;
                        stamp[best] = next_stamp; next_stamp++;
                    end
                end
                K_CHARGE: begin
                    for (int i = 0; i < MAX_PROCS; i++)
                        if (lst[i] == L_READY && grp[i] == e.gid) begin
                            s = gcpu[i] + 17'd20;
                            gcpu[i] = s[16] ? 16'hFFFF : s[15:0];
                        end
                end
                K_QEND: begin
                    groups = '0;
                    for (int g = 1; g <= max_group; g++) begin
                        bit hit;
                        hit = 0;
                        for (int i = 0; i < MAX_PROCS; i++)
                            if (lst[i] != L_FREE && grp[i] == g) hit = 1;
                        if (hit) groups++;
                    end
                    for (int i = 0; i < MAX_PROCS; i++) begin
                        if (lst[i] == L_READY || lst[i] == L_SUSP) begin
                            cpu[i] = cpu[i] >> 1;
                            gcpu[i] = gcpu[i] >> 1;
                        end
                        if (lst[i] == L_READY) begin
                            p = 32'd60 + (cpu[i] >> 1) + ((32'(gcpu[i]) * groups) >> 2);
                            prio[i] = p[18:0];
                        end
                    end
                end
                K_DISPATCH: begin
                    for (int i = 0; i < MAX_PROCS; i++)
                        if (lst[i] == L_READY && (best < 0 || prio[i] < prio[best]
                            || (prio[i] == prio[best] && stamp[i] < stamp[best])))
                            best = i;
                    if (best < 0) r.status = ST_NONE;
                    else begin
                        lst[best] = L_RUN;
                        stamp[best] = next_stamp; next_stamp++;
                        r.chosen_id = pid[best];
                        r.chosen_prio = prio[best];
                    end
                end
                K_MOVE: begin
                    for (int i = 0; i < MAX_PROCS; i++)
                        if (lst[i] != L_FREE && pid[i] == e.pid
                            && (best < 0 || stamp[i] < stamp[best]))
                            best = i;
                    if (best < 0) r.status = ST_NOTFOUND;
                    else begin
                        lst[best] = e.target;
                        if (e.target != L_FREE) begin
                            stamp[best] = next_stamp; next_stamp++;
                        end
                    end
                end
                default: ;
            endcase
            r.groups = groups;
            pending.push_back(r);
        endfunction

        function void check_result(logic [39:0] d);
            t_result x;
            x = '0;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h", $realtime, d);
                return;
            end
            x = pending.pop_front();
            if (d[1:0] !== x.status || d[9:2] !== x.chosen_id
                || d[28:10] !== x.chosen_prio || d[32:29] !== x.groups) begin
                errors++;
                $display("%0t: expected st=%0d id=%0d prio=%0d grp=%0d,",
                    $realtime, x.status, x.chosen_id, x.chosen_prio, x.groups,
                    " got st=%0d id=%0d prio=%0d grp=%0d",
                    d[1:0], d[9:2], d[28:10], d[32:29]);
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [47:0] s_data = '0;
    logic [2:0]  s_user = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [39:0] m_data;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [3:0]  cfg_data = '0;

    sched_scoreboard sb;
    int idle_pct = 0;
    int stall_pct = 0;
    int quiet = 0;

    fair_share_priority_scheduler dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
        .s_axis_tdata(s_data), .s_axis_tuser(s_user),
        .m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // receiver: random stall, check on accept
    always @(posedge clk) begin
        if (rst_n && m_valid && m_ready) sb.check_result(m_data);
        if (rst_n && ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)))
            quiet <= 0;
        else
            quiet <= quiet + 1;
    end

    always @(negedge clk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk) begin
        if (quiet > 20000) begin
            $display("tb_fair_share_priority_scheduler: errors");
            $finish;
        end
    end

    task automatic send_event(t_event e);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct) @(negedge clk);
        s_data <= {2'b0, e.target, e.gcpu, e.cpu, e.gid, e.pid};
        s_user <= e.kind;
        s_valid <= 1;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        sb.note_event(e);
        @(negedge clk);
        s_valid <= 0;
    endtask

    task automatic write_max_group(logic [3:0] v);
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
        cfg_data <= v;
        cfg_valid <= 1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.max_group = v;
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    function automatic t_event make_event(logic [2:0] k, logic [7:0] p, logic [3:0] g,
                                          logic [15:0] c, logic [15:0] gc, logic [1:0] t);
        t_event e;
        e.kind = k; e.pid = p; e.gid = g; e.cpu = c; e.gcpu = gc; e.target = t;
        return e;
    endfunction

    function automatic t_event rand_event();
        t_event e;
        int r;
        r = $urandom_range(99);
        e = make_event(3'($urandom_range(7)), 8'($urandom_range(15)), 4'($urandom_range(15)),
                       16'($urandom), 16'($urandom), 2'($urandom_range(3)));
        if (r < 5) e.pid = 8'($urandom);
        if (r < 30) e.kind = K_INSERT;
        else if (r < 42) e.kind = K_CHARGE;
        else if (r < 55) e.kind = K_QEND;
        else if (r < 75) e.kind = K_DISPATCH;
        else if (r < 97) e.kind = K_MOVE;
        // bias: mostly move instead of insert when near full, insert instead of dispatch when none is ready
        if (e.kind == K_INSERT && sb.count_used() >= MAX_PROCS - 1 && $urandom_range(3) != 0)
            e.kind = K_MOVE;
        if (e.kind == K_DISPATCH && sb.count_ready() == 0 && $urandom_range(3) != 0)
            e.kind = K_INSERT;
        if ($urandom_range(9) == 0) e.cpu = 16'(16'hFFFF - $urandom_range(30));
        if ($urandom_range(9) == 0) e.gcpu = 16'(16'hFFFF - $urandom_range(30));
        return e;
    endfunction

    initial begin
        sb = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // directed: empty dispatch, missing move, extremes, saturation, full table
        send_event(make_event(K_DISPATCH, 8'd0, 4'd0, 16'd0, 16'd0, 2'd0));
        send_event(make_event(K_MOVE, 8'd9, 4'd0, 16'd0, 16'd0, 2'd1));
        send_event(make_event(K_INSERT, 8'hFF, 4'hF, 16'hFFFF, 16'hFFFF, 2'd3));
        send_event(make_event(K_INSERT, 8'h00, 4'h0, 16'h0000, 16'h0000, 2'd0));
        send_event(make_event(K_INSERT, 8'h00, 4'h1, 16'h0000, 16'hFFF0, 2'd0));
        send_event(make_event(K_CHARGE, 8'h00, 4'hF, 16'd0, 16'd0, 2'd0));
        send_event(make_event(K_QEND, 8'h00, 4'h0, 16'd0, 16'd0, 2'd0));
        send_event(make_event(K_DISPATCH, 8'h00, 4'h0, 16'd0, 16'd0, 2'd0));
        send_event(make_event(K_MOVE, 8'h00, 4'h0, 16'd0, 16'd0, 2'd3));
        send_event(make_event(K_MOVE, 8'hFF, 4'h0, 16'd0, 16'd0, 2'd2));
        send_event(make_event(K_MOVE, 8'h00, 4'h0, 16'd0, 16'd0, 2'd0));
        send_event(make_event(3'd5, 8'hAA, 4'h5, 16'h5555, 16'hAAAA, 2'd2));
        send_event(make_event(3'd7, 8'h55, 4'hA, 16'hAAAA, 16'h5555, 2'd1));
        for (int i = 0; i < MAX_PROCS; i++)
            send_event(make_event(K_INSERT, 8'(i), 4'(i), 16'(i * 97), 16'(i * 31), 2'd0));
        send_event(make_event(K_QEND, 8'h00, 4'h0, 16'd0, 16'd0, 2'd0));

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin idle_pct = 0; stall_pct = 0; write_max_group(4'd1); end
                1: begin idle_pct = 78; stall_pct = 0; write_max_group(4'd15); end
                2: begin idle_pct = 0; stall_pct = 78; write_max_group(4'd7); end
                3: begin idle_pct = 30; stall_pct = 30; write_max_group(4'd0); end
                default: begin idle_pct = 0; stall_pct = 0; write_max_group(4'd3); end
            endcase
            for (int n = 0; n < 250; n++) send_event(rand_event());
        end

        while (sb.pending.size() != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_fair_share_priority_scheduler: clean");
        else
            $display("tb_fair_share_priority_scheduler: errors");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/fsps_pkg.sv
rtl/fsps_ram.sv
rtl/fsps_alu.sv
rtl/fair_share_priority_scheduler.sv
bench/tb_fair_share_priority_scheduler.sv
